/* rtl/core/chc_pkg.sv */
package chc_pkg;

    localparam int ANGLE_ITERATIONS_DEFAULT      = 16;
    localparam int HEADING_FRACTION_BITS_DEFAULT = 6;

    localparam int ANGLE_UNIT_BITS = 20;
    localparam int CORDIC_WIDTH    = 32;
    localparam int DIGIT_WIDTH     = 4;
    localparam int DIGIT_COUNT     = CORDIC_WIDTH / DIGIT_WIDTH;
    localparam int TABLE_LEN       = 24;
    localparam int TABLE_INDEX_W   = 5;

    localparam logic [14:0] HEADING_OFFSET_RESET = 15'd7040;

    localparam logic [1:0] OP_SEED    = 2'd0;
    localparam logic [1:0] OP_TRACK   = 2'd1;
    localparam logic [1:0] OP_HEADING = 2'd2;

    typedef struct packed {
        logic        [1:0]  operation;
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
    } t_in_beat;

    typedef struct packed {
        logic        [14:0] heading;
        logic signed [15:0] x_correction;
        logic signed [15:0] y_correction;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic step;
        logic first;
        logic sub;
    } t_lane_ctrl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_LOAD,
        ST_ITER,
        ST_ROUND,
        ST_WRAP_TURN,
        ST_SUB_OFFSET,
        ST_WRAP_OFFSET,
        ST_DONE
    } t_state;

    // Arctangent of 2^-index in 2^-20 degree units, rounded to nearest.
    function automatic logic [CORDIC_WIDTH-1:0] arctan_entry(
        input logic [TABLE_INDEX_W-1:0] index
    );
        logic [CORDIC_WIDTH-1:0] value;
        case (index)
            5'd0:    value = 32'd47185920;
            5'd1:    value = 32'd27855475;
            5'd2:    value = 32'd14718068;
            5'd3:    value = 32'd7471121;
            5'd4:    value = 32'd3750058;
            5'd5:    value = 32'd1876857;
            5'd6:    value = 32'd938658;
            5'd7:    value = 32'd469357;
            5'd8:    value = 32'd234682;
            5'd9:    value = 32'd117342;
            5'd10:   value = 32'd58671;
            5'd11:   value = 32'd29335;
            5'd12:   value = 32'd14668;
            5'd13:   value = 32'd7334;
            5'd14:   value = 32'd3667;
            5'd15:   value = 32'd1833;
            5'd16:   value = 32'd917;
            5'd17:   value = 32'd458;
            5'd18:   value = 32'd229;
            5'd19:   value = 32'd115;
            5'd20:   value = 32'd57;
            5'd21:   value = 32'd29;
            5'd22:   value = 32'd14;
            5'd23:   value = 32'd7;
            default: value = '0;
        endcase
        return value;
    endfunction

endpackage

/* rtl/core/chc_serial_lane.sv */
module chc_serial_lane (
    input  logic                                    i_clk,
    input  chc_pkg::t_lane_ctrl                     i_ctrl,
    input  logic [chc_pkg::CORDIC_WIDTH-1:0]        i_load_value,
    input  logic [chc_pkg::DIGIT_WIDTH-1:0]         i_operand,
    output logic [chc_pkg::CORDIC_WIDTH-1:0]        o_value
);

    logic [chc_pkg::CORDIC_WIDTH-1:0] r_value;
    logic [chc_pkg::CORDIC_WIDTH-1:0] n_value;
    logic                             r_carry;
    logic                             n_carry;
    logic                             carry_in;
    logic [chc_pkg::DIGIT_WIDTH:0]    digit_sum;

    // The register rotates one digit per step, least significant digit first;
    // each new sum digit enters at the top.
    always_comb begin
        carry_in  = i_ctrl.first ? i_ctrl.sub : r_carry;
        digit_sum = {1'b0, r_value[chc_pkg::DIGIT_WIDTH-1:0]}
                  + {1'b0, i_operand ^ {chc_pkg::DIGIT_WIDTH{i_ctrl.sub}}}
                  + {{chc_pkg::DIGIT_WIDTH{1'b0}}, carry_in};
        n_value   = r_value;
        n_carry   = r_carry;
        if (i_ctrl.load) begin
            n_value = i_load_value;
        end else if (i_ctrl.step) begin
            n_value = {digit_sum[chc_pkg::DIGIT_WIDTH-1:0],
                       r_value[chc_pkg::CORDIC_WIDTH-1:chc_pkg::DIGIT_WIDTH]};
            n_carry = digit_sum[chc_pkg::DIGIT_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_carry <= n_carry;
    end

    assign o_value = r_value;

endmodule

/* rtl/core/compass_heading_calibrated.sv */
// Calibrated compass heading with hard-iron correction.
// Input channel (i_in_valid, o_in_ready, i_in_data) carries one sample beat with an
// operation code. A seed beat loads the X and Y minima and maxima with the sample,
// a track beat widens them; both finish in the cycle they are accepted and give no
// result. A heading beat forms the offsets, corrects the sample and runs a CORDIC
// that adds one 4-bit digit per cycle on each of the X, Y and angle lanes. Its
// result leaves on (o_out_valid, i_out_ready, o_out_data) after the iterations,
// the rounding, the angle wrap steps and the offset subtraction; the wrap steps
// repeat until the angle lies within one turn. A zero corrected vector skips the
// iterations. The input channel stays closed while a heading is in flight, so a
// new beat is taken only once that heading has left its last state.
// The output register frees the input side: new beats are taken while a result
// waits. A second heading finishing under a stalled receiver waits in its last
// state until the output register is free.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data) is always ready.
// Reset clears the minima and maxima, drops any pending result and sets the
// heading offset to 110 degrees.
module compass_heading_calibrated #(
    parameter int ANGLE_ITERATIONS      = chc_pkg::ANGLE_ITERATIONS_DEFAULT,
    parameter int HEADING_FRACTION_BITS = chc_pkg::HEADING_FRACTION_BITS_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  chc_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output chc_pkg::t_out_beat o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [14:0]        i_cfg_data
);

    localparam int CW          = chc_pkg::CORDIC_WIDTH;
    localparam int DW          = chc_pkg::DIGIT_WIDTH;
    localparam int ITER_W      = $clog2(ANGLE_ITERATIONS);
    localparam int DIGIT_CNT_W = $clog2(chc_pkg::DIGIT_COUNT);
    localparam int ROUND_SHIFT = chc_pkg::ANGLE_UNIT_BITS - HEADING_FRACTION_BITS;

    localparam logic signed [CW-1:0] FULL_TURN  = CW'(360 << HEADING_FRACTION_BITS);
    localparam logic signed [CW-1:0] ROUND_HALF = CW'(1 << (ROUND_SHIFT - 1));
    localparam logic signed [CW-1:0] QUARTER    = CW'(90 << chc_pkg::ANGLE_UNIT_BITS);
    localparam logic [ITER_W-1:0]      LAST_ITER  = ITER_W'(ANGLE_ITERATIONS - 1);
    localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(chc_pkg::DIGIT_COUNT - 1);

    function automatic logic signed [15:0] offset_of(
        input logic signed [15:0] lowest,
        input logic signed [15:0] highest
    );
        logic signed [16:0] diff;
        logic signed [16:0] half;
        logic signed [17:0] res;
        diff = $signed({highest[15], highest}) - $signed({lowest[15], lowest});
        half = (diff + $signed({16'b0, diff[16]})) >>> 1;
        res  = $signed({half[16], half}) - $signed({{2{highest[15]}}, highest});
        return res[15:0];
    endfunction

    function automatic logic [DW-1:0] shifted_digit(
        input logic [CW-1:0]                     value,
        input logic                              sign,
        input logic [chc_pkg::TABLE_INDEX_W-1:0] shift,
        input logic [DIGIT_CNT_W-1:0]            digit
    );
        logic [DW-1:0] result;
        logic [5:0]    pos;
        logic [6:0]    bit_index;
        for (int k = 0; k < DW; k++) begin
            pos       = {1'b0, shift} + 6'(k);
            bit_index = 7'({digit, 2'b00}) + 7'(pos);
            result[k] = (bit_index < 7'(CW)) ? value[pos[4:0]] : sign;
        end
        return result;
    endfunction

    chc_pkg::t_state r_state;
    chc_pkg::t_state n_state;

    logic signed [15:0] r_x_lowest;
    logic signed [15:0] r_x_highest;
    logic signed [15:0] r_y_lowest;
    logic signed [15:0] r_y_highest;
    logic [14:0]        r_heading_offset;
    logic signed [15:0] r_x_sample;
    logic signed [15:0] r_y_sample;
    logic signed [15:0] r_x_corr;
    logic signed [15:0] r_y_corr;
    logic [ITER_W-1:0]      r_iter;
    logic [DIGIT_CNT_W-1:0] r_digit;
    logic               r_pos;
    logic               r_x_sign;
    logic               r_y_sign;
    logic signed [CW-1:0] r_h;
    logic               r_out_valid;
    chc_pkg::t_out_beat r_out_data;

    logic in_fire;
    logic out_load;
    logic zero_vec;
    logic last_step;

    logic signed [15:0] x_fixed;
    logic signed [15:0] y_fixed;
    logic [CW-1:0] x_scaled;
    logic [CW-1:0] y_scaled;
    logic [CW-1:0] x_start;
    logic [CW-1:0] y_start;
    logic [CW-1:0] ang_start;

    logic [CW-1:0] x_val;
    logic [CW-1:0] y_val;
    logic [CW-1:0] ang_val;
    logic          first_digit;
    logic          x_sgn;
    logic          y_sgn;
    logic          dir_pos;
    logic [chc_pkg::TABLE_INDEX_W-1:0] table_index;
    logic [CW-1:0] table_value;
    logic [DW-1:0] x_operand;
    logic [DW-1:0] y_operand;
    logic [DW-1:0] ang_operand;
    logic signed [CW-1:0] ang_round;

    chc_pkg::t_lane_ctrl x_ctrl;
    chc_pkg::t_lane_ctrl y_ctrl;
    chc_pkg::t_lane_ctrl ang_ctrl;

    assign in_fire     = i_in_valid && o_in_ready;
    assign last_step   = (r_digit == LAST_DIGIT) && (r_iter == LAST_ITER);
    assign o_cfg_ready = 1'b1;

    // Corrected sample, scaled by 256 and turned into the right half plane.
    always_comb begin
        x_fixed   = r_x_sample + r_x_corr;
        y_fixed   = r_y_sample + r_y_corr;
        x_scaled  = {{8{x_fixed[15]}}, x_fixed, 8'h00};
        y_scaled  = {{8{y_fixed[15]}}, y_fixed, 8'h00};
        zero_vec  = (x_fixed == '0) && (y_fixed == '0);
        x_start   = x_scaled;
        y_start   = y_scaled;
        ang_start = '0;
        if (x_fixed[15]) begin
            if (!y_fixed[15]) begin
                x_start   = y_scaled;
                y_start   = -x_scaled;
                ang_start = QUARTER;
            end else begin
                x_start   = -y_scaled;
                y_start   = x_scaled;
                ang_start = -QUARTER;
            end
        end
    end

    always_comb begin
        first_digit = (r_digit == '0);
        x_sgn       = first_digit ? x_val[CW-1] : r_x_sign;
        y_sgn       = first_digit ? y_val[CW-1] : r_y_sign;
        dir_pos     = first_digit ? (!y_val[CW-1] && (|y_val)) : r_pos;
        table_index = chc_pkg::TABLE_INDEX_W'(r_iter);
        table_value = chc_pkg::arctan_entry(table_index);
        x_operand   = shifted_digit(y_val, y_sgn, table_index, r_digit);
        y_operand   = shifted_digit(x_val, x_sgn, table_index, r_digit);
        ang_operand = table_value[{r_digit, 2'b00} +: DW];
        ang_round   = $signed(ang_val) + ROUND_HALF;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            chc_pkg::ST_IDLE: begin
                if (in_fire && (i_in_data.operation == chc_pkg::OP_HEADING)) begin
                    n_state = chc_pkg::ST_PREP;
                end
            end
            chc_pkg::ST_PREP: begin
                n_state = chc_pkg::ST_LOAD;
            end
            chc_pkg::ST_LOAD: begin
                n_state = zero_vec ? chc_pkg::ST_ROUND : chc_pkg::ST_ITER;
            end
            chc_pkg::ST_ITER: begin
                if (last_step) begin
                    n_state = chc_pkg::ST_ROUND;
                end
            end
            chc_pkg::ST_ROUND: begin
                n_state = chc_pkg::ST_WRAP_TURN;
            end
            chc_pkg::ST_WRAP_TURN: begin
                if (!r_h[CW-1] && (r_h < FULL_TURN)) begin
                    n_state = chc_pkg::ST_SUB_OFFSET;
                end
            end
            chc_pkg::ST_SUB_OFFSET: begin
                n_state = chc_pkg::ST_WRAP_OFFSET;
            end
            chc_pkg::ST_WRAP_OFFSET: begin
                if (!r_h[CW-1]) begin
                    n_state = chc_pkg::ST_DONE;
                end
            end
            chc_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = chc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = chc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == chc_pkg::ST_IDLE);
        out_load   = (r_state == chc_pkg::ST_DONE) && (!r_out_valid || i_out_ready);
        x_ctrl.load    = (r_state == chc_pkg::ST_LOAD);
        x_ctrl.step    = (r_state == chc_pkg::ST_ITER);
        x_ctrl.first   = first_digit;
        x_ctrl.sub     = !dir_pos;
        y_ctrl.load    = x_ctrl.load;
        y_ctrl.step    = x_ctrl.step;
        y_ctrl.first   = first_digit;
        y_ctrl.sub     = dir_pos;
        ang_ctrl.load  = x_ctrl.load;
        ang_ctrl.step  = x_ctrl.step;
        ang_ctrl.first = first_digit;
        ang_ctrl.sub   = !dir_pos;
    end

    chc_serial_lane u_x_lane (
        .i_clk        (i_clk),
        .i_ctrl       (x_ctrl),
        .i_load_value (x_start),
        .i_operand    (x_operand),
        .o_value      (x_val)
    );

    chc_serial_lane u_y_lane (
        .i_clk        (i_clk),
        .i_ctrl       (y_ctrl),
        .i_load_value (y_start),
        .i_operand    (y_operand),
        .o_value      (y_val)
    );

    chc_serial_lane u_ang_lane (
        .i_clk        (i_clk),
        .i_ctrl       (ang_ctrl),
        .i_load_value (ang_start),
        .i_operand    (ang_operand),
        .o_value      (ang_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= chc_pkg::ST_IDLE;
            r_out_valid      <= 1'b0;
            r_x_lowest       <= '0;
            r_x_highest      <= '0;
            r_y_lowest       <= '0;
            r_y_highest      <= '0;
            r_heading_offset <= chc_pkg::HEADING_OFFSET_RESET;
            r_iter           <= '0;
            r_digit          <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_heading_offset <= i_cfg_data;
            end
            if (in_fire) begin
                case (i_in_data.operation)
                    chc_pkg::OP_SEED: begin
                        r_x_lowest  <= i_in_data.x_sample;
                        r_x_highest <= i_in_data.x_sample;
                        r_y_lowest  <= i_in_data.y_sample;
                        r_y_highest <= i_in_data.y_sample;
                    end
                    chc_pkg::OP_TRACK: begin
                        if (i_in_data.x_sample < r_x_lowest) begin
                            r_x_lowest <= i_in_data.x_sample;
                        end
                        if (i_in_data.x_sample > r_x_highest) begin
                            r_x_highest <= i_in_data.x_sample;
                        end
                        if (i_in_data.y_sample < r_y_lowest) begin
                            r_y_lowest <= i_in_data.y_sample;
                        end
                        if (i_in_data.y_sample > r_y_highest) begin
                            r_y_highest <= i_in_data.y_sample;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == chc_pkg::ST_LOAD) begin
                r_iter  <= '0;
                r_digit <= '0;
            end else if (r_state == chc_pkg::ST_ITER) begin
                if (r_digit == LAST_DIGIT) begin
                    r_digit <= '0;
                    r_iter  <= r_iter + 1'b1;
                end else begin
                    r_digit <= r_digit + 1'b1;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x_sample <= i_in_data.x_sample;
            r_y_sample <= i_in_data.y_sample;
        end
        if (r_state == chc_pkg::ST_PREP) begin
            r_x_corr <= offset_of(r_x_lowest, r_x_highest);
            r_y_corr <= offset_of(r_y_lowest, r_y_highest);
        end
        if ((r_state == chc_pkg::ST_ITER) && first_digit) begin
            r_pos    <= dir_pos;
            r_x_sign <= x_val[CW-1];
            r_y_sign <= y_val[CW-1];
        end
        case (r_state)
            chc_pkg::ST_ROUND: begin
                r_h <= ang_round >>> ROUND_SHIFT;
            end
            chc_pkg::ST_WRAP_TURN: begin
                if (r_h[CW-1]) begin
                    r_h <= r_h + FULL_TURN;
                end else if (r_h >= FULL_TURN) begin
                    r_h <= r_h - FULL_TURN;
                end
            end
            chc_pkg::ST_SUB_OFFSET: begin
                r_h <= r_h - $signed({{(CW - 15){1'b0}}, r_heading_offset});
            end
            chc_pkg::ST_WRAP_OFFSET: begin
                if (r_h[CW-1]) begin
                    r_h <= r_h + FULL_TURN;
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_data.heading      <= r_h[14:0];
            r_out_data.x_correction <= r_x_corr;
            r_out_data.y_correction <= r_y_corr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/core/chc_checker.sv */
module chc_checker #(
    parameter int HEADING_FRACTION_BITS = chc_pkg::HEADING_FRACTION_BITS_DEFAULT
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input chc_pkg::t_in_beat  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input chc_pkg::t_out_beat o_out_data
);

    localparam int FULL_TURN = 360 << HEADING_FRACTION_BITS;

    logic in_beat;
    assign in_beat = i_in_valid && o_in_ready;

    // A reported heading lies inside one full turn whenever a turn fits the field.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (FULL_TURN > 32767) || (32'(o_out_data.heading) < FULL_TURN))
        else $error("heading outside one full turn");

    // A stalled result beat stays on the port unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");

    // Reset drops any pending result.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A heading beat closes the input channel while it is being worked on.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_in_data.operation == chc_pkg::OP_HEADING)) |=> !o_in_ready)
        else $error("input taken during heading computation");

    // Seed and track beats finish at once and leave the input channel open.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && ((i_in_data.operation == chc_pkg::OP_SEED)
                  || (i_in_data.operation == chc_pkg::OP_TRACK))) |=> o_in_ready)
        else $error("input closed after a calibration beat");

endmodule

bind compass_heading_calibrated chc_checker #(
    .HEADING_FRACTION_BITS (HEADING_FRACTION_BITS)
) u_chc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* verif/tb_compass_heading_calibrated.sv */
`timescale 1ns / 100ps

module tb_compass_heading_calibrated;

    localparam int          HALF_PERIOD       = 5;
    localparam int          RESET_CYCLES      = 12;
    localparam int          CORDIC_STEPS      = chc_pkg::ANGLE_ITERATIONS_DEFAULT;
    localparam int          HEADING_FRAC_BITS = chc_pkg::HEADING_FRACTION_BITS_DEFAULT;
    localparam int          ANGLE_FRAC_BITS   = 20;
    localparam int          SETTLE_CYCLES     = 200;
    localparam int          HOLDOFF_CYCLES    = 900;
    localparam int          RUN_LIMIT_CYCLES  = 3_000_000;
    localparam int          PHASE_ITEMS       = 500;
    localparam logic [1:0]  OP_UNUSED         = 2'd3;
    localparam logic [14:0] OFFSET_AT_RESET   = 15'd7040;
    localparam longint      FULL_TURN         = longint'(360) << HEADING_FRAC_BITS;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    chc_pkg::t_in_beat  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    chc_pkg::t_out_beat out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [14:0]        cfg_data = '0;

    logic signed [15:0] x_min, x_max, y_min, y_max;
    logic [14:0]        declination_setting;
    chc_pkg::t_out_beat expected_headings[$];

    int          cycle_count = 0;
    int          error_count = 0;
    int          burst_left = 0;
    int          holdoff_left = 0;
    logic [15:0] ready_mask = 16'hFFFF;
    int unsigned ready_phase = 0;

    compass_heading_calibrated #(
        .ANGLE_ITERATIONS      (CORDIC_STEPS),
        .HEADING_FRACTION_BITS (HEADING_FRAC_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic longint arctan_of_step(input int step);
        case (step)
            0:       return 47185920;
            1:       return 27855475;
            2:       return 14718068;
            3:       return 7471121;
            4:       return 3750058;
            5:       return 1876857;
            6:       return 938658;
            7:       return 469357;
            8:       return 234682;
            9:       return 117342;
            10:      return 58671;
            11:      return 29335;
            12:      return 14668;
            13:      return 7334;
            14:      return 3667;
            15:      return 1833;
            16:      return 917;
            17:      return 458;
            18:      return 229;
            19:      return 115;
            20:      return 57;
            21:      return 29;
            22:      return 14;
            23:      return 7;
            default: return 0;
        endcase
    endfunction

    function automatic logic signed [15:0] hard_iron_offset(
        input logic signed [15:0] lowest,
        input logic signed [15:0] highest
    );
        int span;
        span = (int'(highest) - int'(lowest)) / 2 - int'(highest);
        return span[15:0];
    endfunction

    // Vectoring CORDIC; the angle comes back in 2^-20 degree units.
    function automatic longint vector_angle(
        input logic signed [15:0] xs,
        input logic signed [15:0] ys
    );
        longint xv, yv, angle, dx, dy, held;
        int     i;
        if (xs == 0 && ys == 0) begin
            return 0;
        end
        xv = longint'(xs) * 256;
        yv = longint'(ys) * 256;
        angle = 0;
        if (xv < 0) begin
            held = xv;
            if (yv >= 0) begin
                xv = yv;
                yv = -held;
                angle = longint'(90) << ANGLE_FRAC_BITS;
            end else begin
                xv = -yv;
                yv = held;
                angle = -(longint'(90) << ANGLE_FRAC_BITS);
            end
        end
        for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv = xv + dx;
                yv = yv - dy;
                angle = angle + arctan_of_step(i);
            end else begin
                xv = xv - dx;
                yv = yv + dy;
                angle = angle - arctan_of_step(i);
            end
        end
        return angle;
    endfunction

    task automatic update_calibration_and_heading(input chc_pkg::t_in_beat beat);
        logic signed [15:0] x_off, y_off, x_fixed, y_fixed;
        longint             degrees;
        int                 drop;
        chc_pkg::t_out_beat want;
        drop = ANGLE_FRAC_BITS - HEADING_FRAC_BITS;
        case (beat.operation)
            chc_pkg::OP_SEED: begin
                x_min = beat.x_sample;
                x_max = beat.x_sample;
                y_min = beat.y_sample;
                y_max = beat.y_sample;
            end
            chc_pkg::OP_TRACK: begin
                if (beat.x_sample < x_min) x_min = beat.x_sample;
                if (beat.x_sample > x_max) x_max = beat.x_sample;
                if (beat.y_sample < y_min) y_min = beat.y_sample;
                if (beat.y_sample > y_max) y_max = beat.y_sample;
            end
            chc_pkg::OP_HEADING: begin
                x_off = hard_iron_offset(x_min, x_max);
                y_off = hard_iron_offset(y_min, y_max);
                x_fixed = beat.x_sample + x_off;
                y_fixed = beat.y_sample + y_off;
                degrees = vector_angle(x_fixed, y_fixed);
                degrees = (degrees + (longint'(1) << (drop - 1))) >>> drop;
                while (degrees < 0) degrees = degrees + FULL_TURN;
                while (degrees >= FULL_TURN) degrees = degrees - FULL_TURN;
                degrees = degrees - longint'(declination_setting);
                while (degrees < 0) degrees = degrees + FULL_TURN;
                want.heading = degrees[14:0];
                want.x_correction = x_off;
                want.y_correction = y_off;
                expected_headings.push_back(want);
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("Mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_result(input chc_pkg::t_out_beat got);
        chc_pkg::t_out_beat want;
        if (expected_headings.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending, heading %0d",
                                      got.heading));
        end else begin
            want = expected_headings.pop_front();
            if (got.heading !== want.heading)
                report_mismatch($sformatf("heading %0d, expected %0d",
                                          got.heading, want.heading));
            if (got.x_correction !== want.x_correction)
                report_mismatch($sformatf("x_correction %0d, expected %0d",
                                          got.x_correction, want.x_correction));
            if (got.y_correction !== want.y_correction)
                report_mismatch($sformatf("y_correction %0d, expected %0d",
                                          got.y_correction, want.y_correction));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            check_result(out_data);
        end
        ready_phase++;
        if (ready_phase % 64 == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_mask = 16'hFFFF;
                1:       ready_mask = 16'($urandom);
                2:       ready_mask = 16'($urandom) & 16'($urandom);
                default: ready_mask = 16'($urandom) | 16'($urandom);
            endcase
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ready_mask[ready_phase % 16];
        end
    end

    initial begin
        while (cycle_count < RUN_LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_sample(
        input logic [1:0]         op,
        input logic signed [15:0] xs,
        input logic signed [15:0] ys
    );
        chc_pkg::t_in_beat beat;
        int                gap;
        beat.operation = op;
        beat.x_sample = xs;
        beat.y_sample = ys;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 160)
                                              : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        update_calibration_and_heading(beat);
        burst_left--;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (expected_headings.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_heading_offset(input logic [14:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        declination_setting = value;
    endtask

    function automatic logic signed [15:0] pick_axis(input int center);
        int value;
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       value = -32768;
                    1:       value = 32767;
                    2:       value = -1;
                    default: value = 0;
                endcase
            end
            1, 2:    value = int'($urandom_range(0, 65535));
            default: value = center + int'($urandom_range(0, 1200)) - 600;
        endcase
        return value[15:0];
    endfunction

    task automatic apply_reset();
        x_min = '0;
        x_max = '0;
        y_min = '0;
        y_max = '0;
        declination_setting = OFFSET_AT_RESET;
        rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_uncalibrated_headings();
        send_sample(chc_pkg::OP_HEADING, 16'sd0, 16'sd0);
        send_sample(chc_pkg::OP_HEADING, 16'sd32767, 16'sd0);
        send_sample(chc_pkg::OP_HEADING, -16'sd32768, 16'sd0);
        send_sample(chc_pkg::OP_HEADING, 16'sd0, -16'sd32768);
        send_sample(chc_pkg::OP_HEADING, -16'sd32768, 16'sd32767);
        send_sample(chc_pkg::OP_HEADING, -16'sd1, -16'sd1);
        send_sample(OP_UNUSED, -16'sd32768, 16'sd32767);
        send_sample(chc_pkg::OP_HEADING, 16'sd0, 16'sd32767);
        drain_results();
    endtask

    task automatic test_calibration_extremes();
        send_sample(chc_pkg::OP_SEED, 16'sd32767, -16'sd32768);
        send_sample(chc_pkg::OP_HEADING, -16'sd32768, 16'sd32767);
        send_sample(chc_pkg::OP_TRACK, -16'sd32768, 16'sd32767);
        send_sample(chc_pkg::OP_HEADING, 16'sd32767, -16'sd32768);
        send_sample(chc_pkg::OP_SEED, -16'sd3, 16'sd7);
        send_sample(chc_pkg::OP_TRACK, 16'sd0, -16'sd7);
        send_sample(chc_pkg::OP_HEADING, -16'sd1, 16'sd0);
        send_sample(chc_pkg::OP_HEADING, 16'sd200, -16'sd900);
        drain_results();
    endtask

    task automatic test_heading_offset_extremes();
        logic [14:0] settings[4];
        int          k;
        settings = '{15'd0, 15'd23039, 15'd23040, 15'd32767};
        for (k = 0; k < 4; k++) begin
            write_heading_offset(settings[k]);
            send_sample(chc_pkg::OP_HEADING, pick_axis(0), pick_axis(0));
            send_sample(chc_pkg::OP_HEADING, 16'sd0, 16'sd0);
        end
        drain_results();
    endtask

    task automatic test_output_holdoff();
        int k;
        send_sample(chc_pkg::OP_SEED, pick_axis(0), pick_axis(0));
        holdoff_left = HOLDOFF_CYCLES;
        for (k = 0; k < 8; k++) begin
            send_sample(chc_pkg::OP_TRACK, pick_axis(0), pick_axis(0));
            send_sample(chc_pkg::OP_HEADING, pick_axis(0), pick_axis(0));
        end
        drain_results();
    endtask

    task automatic test_random_traffic(input int total);
        int sent, k, tracks, headings, cx, cy;
        sent = 0;
        while (sent < total) begin
            if ($urandom_range(0, 99) < 12) begin
                case ($urandom_range(0, 3))
                    0: send_sample(OP_UNUSED, pick_axis(0), pick_axis(0));
                    1: begin
                        send_sample(chc_pkg::OP_HEADING, pick_axis(0), pick_axis(0));
                        sent++;
                    end
                    2: begin
                        send_sample(chc_pkg::OP_TRACK, pick_axis(0), pick_axis(0));
                        sent++;
                    end
                    default: begin
                        send_sample(chc_pkg::OP_SEED, pick_axis(0), pick_axis(0));
                        sent++;
                    end
                endcase
            end else begin
                cx = int'($urandom_range(0, 6000)) - 3000;
                cy = int'($urandom_range(0, 6000)) - 3000;
                tracks = $urandom_range(0, 10);
                headings = $urandom_range(1, 6);
                send_sample(chc_pkg::OP_SEED, pick_axis(cx), pick_axis(cy));
                for (k = 0; k < tracks; k++)
                    send_sample(chc_pkg::OP_TRACK, pick_axis(cx), pick_axis(cy));
                for (k = 0; k < headings; k++)
                    send_sample(chc_pkg::OP_HEADING, pick_axis(cx), pick_axis(cy));
                sent += 1 + tracks + headings;
            end
            if ($urandom_range(0, 49) == 0) begin
                drain_results();
            end
        end
    endtask

    initial begin
        apply_reset();
        test_uncalibrated_headings();
        test_calibration_extremes();
        test_heading_offset_extremes();
        test_output_holdoff();
        write_heading_offset(OFFSET_AT_RESET);
        test_random_traffic(PHASE_ITEMS);
        write_heading_offset(15'($urandom_range(0, 32767)));
        test_random_traffic(PHASE_ITEMS);
        write_heading_offset(15'd23039);
        test_random_traffic(PHASE_ITEMS);
        write_heading_offset(15'd0);
        test_random_traffic(PHASE_ITEMS);
        drain_results();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/chc_pkg.sv
rtl/core/chc_serial_lane.sv
rtl/core/compass_heading_calibrated.sv
rtl/core/chc_checker.sv
verif/tb_compass_heading_calibrated.sv
